[rtl/waypoint_path_interpolator_macros.svh]
// Assertion macros for the waypoint path interpolator.
// Used by the controller and datapath modules; no other dependencies.
`ifndef WAYPOINT_PATH_INTERPOLATOR_MACROS_SVH
`define WAYPOINT_PATH_INTERPOLATOR_MACROS_SVH

// same-cycle implication
`define WPI_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define WPI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/wpi_pkg.sv]
// Shared types and constants for the waypoint path interpolator.
// No dependencies.
`default_nettype none
package wpi_pkg;

   localparam int unsigned T_ONE      = 65536;
   localparam int unsigned STEP_MAX   = 131072;
   localparam int unsigned SQRT_STEPS = 34;
   localparam int unsigned DIV_STEPS  = 56;

   typedef enum logic [1:0] {
      CMD_TICK   = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_SPEED     = 2'd0,
      CSR_LOOP      = 2'd1,
      CSR_PING_PONG = 2'd2,
      CSR_UNUSED    = 2'd3
   } csr_idx_type;

   typedef enum logic [1:0] {
      AX_X = 2'd0,
      AX_Y = 2'd1,
      AX_Z = 2'd2,
      AX_NONE = 2'd3
   } axis_type;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LATCH,
      OP_FULL,
      OP_WRITE,
      OP_SQ,
      OP_SQRT_INIT,
      OP_SQRT_STEP,
      OP_LEN_ACC,
      OP_CLEAR,
      OP_END,
      OP_MUL,
      OP_DIV_STEP,
      OP_TICK_UPD,
      OP_SEG,
      OP_READ,
      OP_LERP
   } op_type;

   typedef struct packed {
      op_type   op;
      axis_type axis;
      logic     load;
   } dp_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    full;
      logic    has_prev;
      logic    tick_ok;
      logic    len_zero;
   } dp_stat_type;

endpackage
`default_nettype wire

[rtl/wpi_dp.sv]
// Datapath: waypoint memory, square root, divider, interpolation, output register.
// Depends on wpi_pkg and waypoint_path_interpolator_macros.svh.
`default_nettype none
`include "waypoint_path_interpolator_macros.svh"
module wpi_dp
   import wpi_pkg::*;
#(
   parameter int MAX_POINTS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire dp_cmd_type         cmd,
   output dp_stat_type             stat,
   input  wire logic [1:0]         req_command,
   input  wire logic [23:0]        req_delta_time,
   input  wire logic signed [31:0] req_point_x,
   input  wire logic signed [31:0] req_point_y,
   input  wire logic signed [31:0] req_point_z,
   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_data,
   output logic signed [31:0]      rsp_position_x,
   output logic signed [31:0]      rsp_position_y,
   output logic signed [31:0]      rsp_position_z,
   output logic [16:0]             rsp_path_position,
   output logic                    rsp_heading_forward,
   output logic                    rsp_status
);

   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int TW = 17 + CW;
   localparam int RW = 38;

   // configuration
   logic [31:0] speed_ff;
   logic        loop_ff, pp_ff;

   // captured request
   cmd_type            cmd_ff;
   logic [23:0]        dt_ff;
   logic signed [31:0] px_ff, py_ff, pz_ff;

   // path state
   logic [95:0]   mem [MAX_POINTS];
   logic [95:0]   rda_ff, rdb_ff;
   logic [CW-1:0] count_ff;
   logic [47:0]   len_ff;
   logic [16:0]   t_ff;
   logic          fwd_ff;
   logic          status_ff;

   // work registers
   logic [65:0]   acc_ff;
   logic [67:0]   sq_num_ff;
   logic [RW-1:0] sq_rem_ff;
   logic [33:0]   sq_root_ff;
   logic [55:0]   dv_dvd_ff;
   logic [48:0]   dv_rem_ff;
   logic [55:0]   dv_quo_ff;
   logic [IW-1:0] seg_ff;
   logic [16:0]   frac_ff;
   logic signed [31:0] lx_ff, ly_ff, lz_ff;

   // ---------------- combinational helpers ----------------
   logic [CW-1:0] cnt_m1, cnt_m2;
   logic [IW-1:0] addr_a, addr_b;
   logic          rd_en;
   logic signed [31:0] cur, prv;
   logic signed [32:0] diff;
   logic [31:0]   mag;
   logic [63:0]   sq;
   logic [RW-1:0] rem_sh, trial;
   logic [48:0]   dv_sh;
   logic [48:0]   len_sum;
   logic [17:0]   step;
   logic signed [19:0] t_new;
   logic          at_end, at_start;
   logic [16:0]   end_t;
   logic          end_fwd;
   logic [TW-1:0] tt;
   logic [CW-1:0] seg_raw;
   logic signed [31:0] la, lb;
   logic signed [32:0] ldiff;
   logic signed [50:0] lprod;
   logic signed [31:0] lres;

   assign cnt_m1 = count_ff - CW'(1);
   assign cnt_m2 = count_ff - CW'(2);

   always_comb begin
      if (cmd.op == OP_WRITE) begin
         addr_a = cnt_m1[IW-1:0];
      end else begin
         addr_a = seg_ff;
      end
      addr_b = IW'(seg_ff + IW'(1));
      rd_en  = (cmd.op == OP_WRITE) || (cmd.op == OP_READ);
   end

   // squared axis difference for segment length
   always_comb begin
      case (cmd.axis)
         AX_X: begin cur = px_ff; prv = rda_ff[95:64]; end
         AX_Y: begin cur = py_ff; prv = rda_ff[63:32]; end
         default: begin cur = pz_ff; prv = rda_ff[31:0]; end
      endcase
      diff = {cur[31], cur} - {prv[31], prv};
      mag  = diff[32] ? 32'(-diff) : diff[31:0];
      sq   = {32'd0, mag} * {32'd0, mag};
   end

   // one step of digit-by-digit square root
   assign rem_sh = {sq_rem_ff[RW-3:0], sq_num_ff[67:66]};
   assign trial  = {(RW - 36)'(0), sq_root_ff, 2'b01};

   // one step of restoring division
   assign dv_sh = {dv_rem_ff[47:0], dv_dvd_ff[55]};

   assign len_sum = {1'b0, len_ff} + {15'd0, sq_root_ff};

   // tick step and path end handling
   always_comb begin
      step = (dv_quo_ff > 56'(STEP_MAX)) ? 18'(STEP_MAX) : dv_quo_ff[17:0];
      if (fwd_ff) begin
         t_new = $signed({3'd0, t_ff}) + $signed({2'd0, step});
      end else begin
         t_new = $signed({3'd0, t_ff}) - $signed({2'd0, step});
      end
      if (cmd.op == OP_END) begin
         at_end   = fwd_ff;
         at_start = !fwd_ff;
      end else begin
         at_end   = t_new >= $signed(20'(T_ONE));
         at_start = !at_end && t_new <= $signed(20'd0);
      end
      end_fwd  = fwd_ff;
      if (at_end) begin
         if (pp_ff) begin
            end_t = 17'(T_ONE); end_fwd = 1'b0;
         end else if (loop_ff) begin
            end_t = 17'd0;
         end else begin
            end_t = 17'(T_ONE);
         end
      end else begin
         if (pp_ff) begin
            end_t = 17'd0; end_fwd = 1'b1;
         end else if (loop_ff) begin
            end_t = 17'(T_ONE);
         end else begin
            end_t = 17'd0;
         end
      end
   end

   // segment index and fraction
   always_comb begin
      tt      = TW'(t_ff) * TW'(cnt_m1);
      seg_raw = tt[16 +: CW];
   end

   // interpolation of one axis
   always_comb begin
      case (cmd.axis)
         AX_X: begin la = rda_ff[95:64]; lb = rdb_ff[95:64]; end
         AX_Y: begin la = rda_ff[63:32]; lb = rdb_ff[63:32]; end
         default: begin la = rda_ff[31:0]; lb = rdb_ff[31:0]; end
      endcase
      ldiff = {lb[31], lb} - {la[31], la};
      lprod = ldiff * $signed({1'b0, frac_ff});
      lres  = la + lprod[47:16];
   end

   always_comb begin
      stat.cmd      = cmd_ff;
      stat.full     = count_ff >= CW'(MAX_POINTS);
      stat.has_prev = count_ff != '0;
      stat.tick_ok  = count_ff >= CW'(2);
      stat.len_zero = len_ff == '0;
   end

   // ---------------- memory ----------------
   always_ff @(posedge clock) begin
      if (cmd.op == OP_WRITE) begin
         mem[count_ff[IW-1:0]] <= {px_ff, py_ff, pz_ff};
      end
      if (rd_en) begin
         rda_ff <= mem[addr_a];
         rdb_ff <= mem[addr_b];
      end
   end

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= 32'(T_ONE);
         loop_ff  <= 1'b0;
         pp_ff    <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_SPEED:     speed_ff <= csr_data;
            CSR_LOOP:      loop_ff  <= csr_data[0];
            CSR_PING_PONG: pp_ff    <= csr_data[0];
            default: ;
         endcase
      end
   end

   // ---------------- path state ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         len_ff    <= '0;
         t_ff      <= '0;
         fwd_ff    <= 1'b1;
         cmd_ff    <= CMD_TICK;
         status_ff <= 1'b0;
      end else begin
         unique case (cmd.op)
            OP_LATCH: begin
               cmd_ff    <= cmd_type'(req_command);
               status_ff <= 1'b0;
            end
            OP_FULL:  status_ff <= 1'b1;
            OP_WRITE: count_ff <= count_ff + CW'(1);
            OP_LEN_ACC: begin
               len_ff <= len_sum[48] ? '1 : len_sum[47:0];
            end
            OP_CLEAR: begin
               count_ff <= '0;
               len_ff   <= '0;
               t_ff     <= '0;
            end
            OP_END: begin
               t_ff   <= end_t;
               fwd_ff <= end_fwd;
            end
            OP_TICK_UPD: begin
               // landing exactly on an end also counts as reaching it
               if (at_end || at_start) begin
                  t_ff   <= end_t;
                  fwd_ff <= end_fwd;
               end else begin
                  t_ff <= t_new[16:0];
               end
            end
            default: ;
         endcase
      end
   end

   // ---------------- work registers ----------------
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LATCH: begin
            dt_ff <= req_delta_time;
            px_ff <= req_point_x;
            py_ff <= req_point_y;
            pz_ff <= req_point_z;
         end
         OP_WRITE: acc_ff <= '0;
         OP_SQ:    acc_ff <= acc_ff + {2'd0, sq};
         OP_SQRT_INIT: begin
            sq_num_ff  <= {2'd0, acc_ff};
            sq_rem_ff  <= '0;
            sq_root_ff <= '0;
         end
         OP_SQRT_STEP: begin
            sq_num_ff <= {sq_num_ff[65:0], 2'd0};
            if (rem_sh >= trial) begin
               sq_rem_ff  <= rem_sh - trial;
               sq_root_ff <= {sq_root_ff[32:0], 1'b1};
            end else begin
               sq_rem_ff  <= rem_sh;
               sq_root_ff <= {sq_root_ff[32:0], 1'b0};
            end
         end
         OP_MUL: begin
            dv_dvd_ff <= {24'd0, speed_ff} * {32'd0, dt_ff};
            dv_rem_ff <= '0;
            dv_quo_ff <= '0;
         end
         OP_DIV_STEP: begin
            dv_dvd_ff <= {dv_dvd_ff[54:0], 1'b0};
            if (dv_sh >= {1'b0, len_ff}) begin
               dv_rem_ff <= dv_sh - {1'b0, len_ff};
               dv_quo_ff <= {dv_quo_ff[54:0], 1'b1};
            end else begin
               dv_rem_ff <= dv_sh;
               dv_quo_ff <= {dv_quo_ff[54:0], 1'b0};
            end
         end
         OP_SEG: begin
            if (count_ff < CW'(2)) begin
               seg_ff  <= '0;
               frac_ff <= '0;
            end else if (seg_raw >= cnt_m1) begin
               seg_ff  <= cnt_m2[IW-1:0];
               frac_ff <= 17'(T_ONE);
            end else begin
               seg_ff  <= seg_raw[IW-1:0];
               frac_ff <= {1'b0, tt[15:0]};
            end
         end
         OP_LERP: begin
            case (cmd.axis)
               AX_X:    lx_ff <= lres;
               AX_Y:    ly_ff <= lres;
               default: lz_ff <= lres;
            endcase
         end
         default: ;
      endcase
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         if (count_ff == '0) begin
            rsp_position_x <= '0;
            rsp_position_y <= '0;
            rsp_position_z <= '0;
         end else if (count_ff == CW'(1)) begin
            rsp_position_x <= rda_ff[95:64];
            rsp_position_y <= rda_ff[63:32];
            rsp_position_z <= rda_ff[31:0];
         end else begin
            rsp_position_x <= lx_ff;
            rsp_position_y <= ly_ff;
            rsp_position_z <= lz_ff;
         end
         rsp_path_position   <= t_ff;
         rsp_heading_forward <= fwd_ff;
         rsp_status          <= status_ff;
      end
   end

   `WPI_ASSERT_NOW(a_t_range, clock, reset, 1'b1, t_ff <= 17'(T_ONE), "path parameter above 1.0")
   `WPI_ASSERT_NOW(a_count_range, clock, reset, 1'b1, count_ff <= CW'(MAX_POINTS),
                   "waypoint count above capacity")
   `WPI_ASSERT_NEXT(a_full_keeps, clock, reset, cmd.op == OP_FULL,
                    count_ff == $past(count_ff) && rsp_status == $past(rsp_status),
                    "ignored append changed state")

endmodule
`default_nettype wire

[rtl/wpi_ctrl.sv]
// Sequencer for the waypoint path interpolator: handshakes and datapath commands.
// Depends on wpi_pkg and waypoint_path_interpolator_macros.svh.
`default_nettype none
`include "waypoint_path_interpolator_macros.svh"
module wpi_ctrl
   import wpi_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   input  wire dp_stat_type stat,
   output dp_cmd_type       cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_SQ_X, S_SQ_Y, S_SQ_Z, S_SQRT_INIT, S_SQRT, S_LEN,
      S_DIV, S_UPD, S_SEG, S_READ, S_LERP_X, S_LERP_Y, S_LERP_Z, S_LOAD
   } state_type;

   state_type  state_ff, state_in;
   logic [5:0] iter_ff, iter_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      iter_in      = iter_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = OP_IDLE;
      cmd.axis     = AX_NONE;
      cmd.load     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LATCH;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_SEG;
            case (stat.cmd)
               CMD_APPEND: begin
                  if (stat.full) begin
                     cmd.op = OP_FULL;
                  end else begin
                     cmd.op = OP_WRITE;
                     if (stat.has_prev) state_in = S_SQ_X;
                  end
               end
               CMD_TICK: begin
                  if (stat.tick_ok) begin
                     if (stat.len_zero) begin
                        cmd.op = OP_END;
                     end else begin
                        cmd.op   = OP_MUL;
                        iter_in  = '0;
                        state_in = S_DIV;
                     end
                  end
               end
               CMD_CLEAR: cmd.op = OP_CLEAR;
               default: ;
            endcase
         end
         S_SQ_X: begin cmd.op = OP_SQ; cmd.axis = AX_X; state_in = S_SQ_Y; end
         S_SQ_Y: begin cmd.op = OP_SQ; cmd.axis = AX_Y; state_in = S_SQ_Z; end
         S_SQ_Z: begin cmd.op = OP_SQ; cmd.axis = AX_Z; state_in = S_SQRT_INIT; end
         S_SQRT_INIT: begin
            cmd.op   = OP_SQRT_INIT;
            iter_in  = '0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.op  = OP_SQRT_STEP;
            iter_in = iter_ff + 6'd1;
            if (iter_ff == 6'(SQRT_STEPS - 1)) state_in = S_LEN;
         end
         S_LEN: begin cmd.op = OP_LEN_ACC; state_in = S_SEG; end
         S_DIV: begin
            cmd.op  = OP_DIV_STEP;
            iter_in = iter_ff + 6'd1;
            if (iter_ff == 6'(DIV_STEPS - 1)) state_in = S_UPD;
         end
         S_UPD:  begin cmd.op = OP_TICK_UPD; state_in = S_SEG; end
         S_SEG:  begin cmd.op = OP_SEG; state_in = S_READ; end
         S_READ: begin cmd.op = OP_READ; state_in = S_LERP_X; end
         S_LERP_X: begin cmd.op = OP_LERP; cmd.axis = AX_X; state_in = S_LERP_Y; end
         S_LERP_Y: begin cmd.op = OP_LERP; cmd.axis = AX_Y; state_in = S_LERP_Z; end
         S_LERP_Z: begin cmd.op = OP_LERP; cmd.axis = AX_Z; state_in = S_LOAD; end
         S_LOAD: begin
            // wait until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `WPI_ASSERT_NEXT(a_accept_dispatch, clock, reset, req_valid && req_ready,
                    state_ff == S_DISPATCH, "accepted request not dispatched")
   `WPI_ASSERT_NEXT(a_load_waits, clock, reset,
                    state_ff == S_LOAD && rsp_valid_ff && !rsp_ready,
                    state_ff == S_LOAD && rsp_valid_ff, "result overwritten while pending")
   `WPI_ASSERT_NOW(a_iter_bound, clock, reset, state_ff == S_SQRT,
                   iter_ff < 6'(SQRT_STEPS), "square root ran past its steps")

endmodule
`default_nettype wire

[rtl/waypoint_path_interpolator.sv]
// Waypoint path interpolator. A tick runs the 56-step divider loop, an append the 34-step
// square root loop; other requests, ticks with under two points or zero length and appends
// to an empty or full table run neither loop.
// One request in flight; the next is accepted in the cycle after the result loads.
// The output register holds a finished result while the next request is taken.
// Synchronous active-high reset: empty table, t = 0, forward, speed 1.0; no clearing pass.
`default_nettype none
module waypoint_path_interpolator
   import wpi_pkg::*;
#(
   parameter int MAX_POINTS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_command,
   input  wire logic [23:0]        req_delta_time,
   input  wire logic signed [31:0] req_point_x,
   input  wire logic signed [31:0] req_point_y,
   input  wire logic signed [31:0] req_point_z,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_position_x,
   output logic signed [31:0]      rsp_position_y,
   output logic signed [31:0]      rsp_position_z,
   output logic [16:0]             rsp_path_position,
   output logic                    rsp_heading_forward,
   output logic                    rsp_status,
   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_data
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   wpi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   wpi_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_command         (req_command),
      .req_delta_time      (req_delta_time),
      .req_point_x         (req_point_x),
      .req_point_y         (req_point_y),
      .req_point_z         (req_point_z),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .rsp_position_x      (rsp_position_x),
      .rsp_position_y      (rsp_position_y),
      .rsp_position_z      (rsp_position_z),
      .rsp_path_position   (rsp_path_position),
      .rsp_heading_forward (rsp_heading_forward),
      .rsp_status          (rsp_status)
   );

endmodule
`default_nettype wire
